// File: src/url_component_tokenizer_macros.svh
// Assertion macros for the URL component tokenizer.
// Used by the top level; no other dependencies.
`ifndef URL_COMPONENT_TOKENIZER_MACROS_SVH
`define URL_COMPONENT_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define UCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("url tokenizer assertion failed");
`define UCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("url tokenizer assertion failed");
`else
`define UCT_ASSERT(label, clk, rst_n, prop)
`define UCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/uct_pkg.sv
// Package for the URL component tokenizer: codes, transition table, bundle type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package uct_pkg;

    localparam int unsigned STATE_W     = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [STATE_W-1:0] ST_START = 4'd0;
    localparam logic [STATE_W-1:0] ST_ERROR = 4'd8;
    localparam logic [STATE_W-1:0] ST_HOST  = 4'd1;
    localparam logic [STATE_W-1:0] ST_PATH  = 4'd2;
    localparam logic [STATE_W-1:0] ST_PORT  = 4'd5;
    localparam logic [STATE_W-1:0] ST_SEP   = 4'd7;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_COLON = 3'd1;
    localparam logic [2:0] CLS_SLASH = 3'd2;
    localparam logic [2:0] CLS_QUERY = 3'd3;
    localparam logic [2:0] CLS_HASH  = 3'd4;

    localparam logic [2:0] COMP_SCHEME   = 3'd0;
    localparam logic [2:0] COMP_DOMAIN   = 3'd1;
    localparam logic [2:0] COMP_PORT     = 3'd2;
    localparam logic [2:0] COMP_PATH     = 3'd3;
    localparam logic [2:0] COMP_QUERY    = 3'd4;
    localparam logic [2:0] COMP_FRAGMENT = 3'd5;
    localparam logic [2:0] COMP_NONE     = 3'd7;

    // Bits of the result mask, in the order the results leave the block.
    localparam int unsigned RES_PRE  = 0;
    localparam int unsigned RES_PAY  = 1;
    localparam int unsigned RES_POST = 2;
    localparam int unsigned RES_FIN  = 3;
    localparam int unsigned RES_N    = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_FINISH  = 2'd2
    } t_kind;

    localparam logic [STATE_W-1:0] MOVE_TABLE [0:7][0:4] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4},
        '{4'd5, 4'd8, 4'd7, 4'd8, 4'd8},
        '{4'd2, 4'd8, 4'd2, 4'd3, 4'd4},
        '{4'd3, 4'd8, 4'd8, 4'd8, 4'd4},
        '{4'd4, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd5, 4'd8, 4'd2, 4'd8, 4'd8},
        '{4'd6, 4'd5, 4'd2, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd6, 4'd8, 4'd8}
    };

    // Work for one accepted item, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]       byte_val;
        logic [2:0]       post_comp;
        logic             url_ok;
        logic [RES_N-1:0] mask;
    } t_bundle;

    typedef struct packed {
        logic [STATE_W-1:0] state;
    } t_front_status;

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            8'h3A:   c = CLS_COLON;
            8'h2F:   c = CLS_SLASH;
            8'h3F:   c = CLS_QUERY;
            8'h23:   c = CLS_HASH;
            default: c = CLS_OTHER;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] closed_component(input logic [STATE_W-1:0] st,
                                                    input logic [STATE_W-1:0] nx,
                                                    input logic eol);
        logic [2:0] c;
        c = COMP_NONE;
        case (st)
            4'd0: if (nx inside {[4'd2:4'd4]} || (eol && nx == 4'd0)) c = COMP_DOMAIN;
            4'd1: if (nx == 4'd7) c = COMP_SCHEME;
            4'd2: if (nx == 4'd3 || nx == 4'd4 || (eol && nx == 4'd2)) c = COMP_PATH;
            4'd3: if (nx == 4'd4 || (eol && nx == 4'd3)) c = COMP_QUERY;
            4'd4: if (eol && nx == 4'd4) c = COMP_FRAGMENT;
            4'd5: if (nx == 4'd2 || (eol && nx == 4'd5)) c = COMP_PORT;
            4'd6: if (nx == 4'd2 || nx == 4'd5 || (eol && nx == 4'd6)) c = COMP_DOMAIN;
            default: c = COMP_NONE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/uct_if.sv
// Valid/ready channel interfaces of the URL component tokenizer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface uct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_line;

    modport source (output valid, output in_byte, output end_of_line, input ready);
    modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface uct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] byte_value;
    logic [2:0] component_id;
    logic       url_valid;
    logic       last_of_run;

    modport source (output valid, output result_kind, output byte_value,
                    output component_id, output url_valid, output last_of_run,
                    input ready);
    modport sink (input valid, input result_kind, input byte_value,
                  input component_id, input url_valid, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// File: src/uct_front.sv
// Front part: classifies each byte, steps the parse state and builds the
// result bundle for the back part. Depends on uct_pkg and uct_if.
`timescale 1ns / 1ps
`default_nettype none
module uct_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    uct_in_if.sink               i_url,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output uct_pkg::t_bundle     o_bundle,
    output uct_pkg::t_front_status o_status
);

    logic [uct_pkg::STATE_W-1:0] r_state;
    logic [uct_pkg::STATE_W-1:0] n_state;
    logic [uct_pkg::STATE_W-1:0] st;
    logic [uct_pkg::STATE_W-1:0] nx;
    logic [uct_pkg::STATE_W-1:0] st_after;
    logic [2:0]                  cls;
    logic [2:0]                  comp;
    logic                        eol;
    logic                        accept;

    assign eol    = i_url.end_of_line;
    assign accept = i_url.valid && !i_q_full;
    assign i_url.ready = !i_q_full;

    always_comb begin
        st       = (r_state > uct_pkg::ST_ERROR) ? uct_pkg::ST_ERROR : r_state;
        cls      = uct_pkg::byte_class(i_url.in_byte);
        nx       = uct_pkg::ST_ERROR;
        comp     = uct_pkg::COMP_NONE;
        o_bundle = '0;
        o_bundle.byte_val  = i_url.in_byte;
        o_bundle.post_comp = uct_pkg::COMP_NONE;
        if (st != uct_pkg::ST_ERROR) begin
            nx = uct_pkg::MOVE_TABLE[st[2:0]][cls];
        end
        if (st != uct_pkg::ST_ERROR && nx != uct_pkg::ST_ERROR) begin
            if (st == uct_pkg::ST_HOST && nx == uct_pkg::ST_PORT) begin
                // host:port closes the domain, then opens the port
                o_bundle.mask[uct_pkg::RES_PRE]  = 1'b1;
                o_bundle.mask[uct_pkg::RES_PAY]  = 1'b1;
                o_bundle.mask[uct_pkg::RES_POST] = eol;
                o_bundle.post_comp               = uct_pkg::COMP_PORT;
            end else begin
                comp = uct_pkg::closed_component(st, nx, eol);
                o_bundle.mask[uct_pkg::RES_PAY] = (cls == uct_pkg::CLS_OTHER) ||
                    (cls == uct_pkg::CLS_SLASH && st == uct_pkg::ST_PATH);
                o_bundle.mask[uct_pkg::RES_POST] = (comp != uct_pkg::COMP_NONE);
                o_bundle.post_comp               = comp;
            end
        end
        st_after = (st == uct_pkg::ST_ERROR) ? uct_pkg::ST_ERROR : nx;
        o_bundle.mask[uct_pkg::RES_FIN] = eol;
        o_bundle.url_ok = !(st_after == uct_pkg::ST_ERROR || st_after == uct_pkg::ST_HOST ||
                            st_after == uct_pkg::ST_SEP);
        n_state = r_state;
        if (accept) begin
            n_state = eol ? uct_pkg::ST_START : st_after;
        end
    end

    assign o_push = accept && (o_bundle.mask != '0);
    assign o_status.state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uct_pkg::ST_START;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: src/uct_queue.sv
// Short queue of result bundles between the front and the back part.
// Depends on uct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uct_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire uct_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output uct_pkg::t_bundle       o_head
);

    localparam int unsigned PTR_W = $clog2(uct_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(uct_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(uct_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(uct_pkg::QUEUE_DEPTH - 1);

    uct_pkg::t_bundle r_mem [uct_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/uct_back.sv
// Back part: sends the results of the queue-head bundle one per cycle
// unless o_tok stalls, via an output register. Depends on uct_pkg, uct_if.
`timescale 1ns / 1ps
`default_nettype none
module uct_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire uct_pkg::t_bundle i_q_head,
    output logic                  o_pop,
    uct_out_if.source             o_tok
);

    uct_pkg::t_bundle          r_bund;
    logic [uct_pkg::RES_N-1:0] r_mask;
    logic                      r_out_valid;
    uct_pkg::t_kind            r_kind;
    logic [7:0]                r_byte;
    logic [2:0]                r_comp;
    logic                      r_ok;
    logic                      r_last;

    uct_pkg::t_bundle          src;
    logic [uct_pkg::RES_N-1:0] src_mask;
    logic [uct_pkg::RES_N-1:0] rem_mask;
    logic                      from_cur;
    logic                      can_load;
    logic                      load;
    uct_pkg::t_kind            n_kind;
    logic [7:0]                n_byte;
    logic [2:0]                n_comp;
    logic                      n_ok;

    assign from_cur = (r_mask != '0);
    assign src      = from_cur ? r_bund : i_q_head;
    assign src_mask = from_cur ? r_mask : i_q_head.mask;
    assign can_load = !r_out_valid || o_tok.ready;
    assign load     = can_load && (from_cur || i_q_valid);
    assign o_pop    = load && !from_cur;
    // clear the lowest pending result
    assign rem_mask = src_mask & (src_mask - 1'b1);

    always_comb begin
        n_kind = uct_pkg::KIND_FINISH;
        n_byte = '0;
        n_comp = '0;
        n_ok   = 1'b0;
        if (src_mask[uct_pkg::RES_PRE]) begin
            n_kind = uct_pkg::KIND_CLOSE;
            n_comp = uct_pkg::COMP_DOMAIN;
        end else if (src_mask[uct_pkg::RES_PAY]) begin
            n_kind = uct_pkg::KIND_PAYLOAD;
            n_byte = src.byte_val;
        end else if (src_mask[uct_pkg::RES_POST]) begin
            n_kind = uct_pkg::KIND_CLOSE;
            n_comp = src.post_comp;
        end else begin
            n_ok = src.url_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bund <= src;
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_comp <= n_comp;
            r_ok   <= n_ok;
            r_last <= (rem_mask == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mask      <= rem_mask;
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tok.valid        = r_out_valid;
    assign o_tok.result_kind  = r_kind;
    assign o_tok.byte_value   = r_byte;
    assign o_tok.component_id = r_comp;
    assign o_tok.url_valid    = r_ok;
    assign o_tok.last_of_run  = r_last;

endmodule
`default_nettype wire

// File: src/url_component_tokenizer.sv
// URL component tokenizer: bytes of a URL line come in on i_url, and
// results telling the receiver how to split the line leave on o_tok.
// Each item on i_url is one character plus an end-of-line flag. Each item
// on o_tok is a payload byte, a close marker naming the component the
// receiver's buffered bytes form, or a line-finished report with validity.
// One input item causes zero to four result items; the last of them has
// last_of_run set. After an error the block drops bytes until line end.
// The first result of an item passes through the queue and then the
// output register before it shows on o_tok. The output register sends
// one result per cycle while the receiver is ready; an item with no
// results is not queued. A two-entry queue between the classifying front
// and the sending back lets the next bytes be taken while results drain.
// When the receiver stalls, the output holds and the queue fills, then
// i_url.ready drops. Reset clears the parse state to start of line and
// empties the queue and the output register.
// Depends on uct_pkg, uct_if, uct_front, uct_queue, uct_back and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "url_component_tokenizer_macros.svh"
module url_component_tokenizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    uct_in_if.sink    i_url,
    uct_out_if.source o_tok
);

    logic                  q_full;
    logic                  q_valid;
    logic                  push;
    logic                  pop;
    uct_pkg::t_bundle      push_bundle;
    uct_pkg::t_bundle      q_head;
    uct_pkg::t_front_status front_st;
    logic                  eol_accept;
    logic                  finish_out;

    uct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_url    (i_url),
        .i_q_full (q_full),
        .o_push   (push),
        .o_bundle (push_bundle),
        .o_status (front_st)
    );

    uct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    uct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_tok     (o_tok)
    );

    assign eol_accept = i_url.valid && i_url.ready && i_url.end_of_line;
    assign finish_out = o_tok.valid && (o_tok.result_kind == uct_pkg::KIND_FINISH);

    `UCT_ASSERT(a_state_in_range, i_clk, i_rst_n, front_st.state <= uct_pkg::ST_ERROR)
    `UCT_ASSERT_NEXT(a_eol_restarts, i_clk, i_rst_n, eol_accept, front_st.state == uct_pkg::ST_START)
    `UCT_ASSERT(a_finish_is_last, i_clk, i_rst_n, finish_out |-> o_tok.last_of_run)
    `UCT_ASSERT(a_no_push_when_full, i_clk, i_rst_n, push |-> !q_full)

endmodule
`default_nettype wire
